FILE: rtl/kwdt_pkg.sv
package kwdt_pkg;

  // Width of the tick counter.
  localparam int COUNT_WIDTH = 16;
  // Width used to compare the counter against the 16-bit match value.
  localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register byte offsets.
  localparam logic [7:0] OFS_FIRST  = 8'hb0;
  localparam logic [7:0] OFS_SECOND = 8'hb4;
  localparam logic [7:0] OFS_ENABLE = 8'hb8;
  localparam logic [7:0] OFS_MATCH  = 8'hbc;
  localparam logic [7:0] OFS_STATUS = 8'hc0;
  localparam logic [7:0] OFS_CLEAR  = 8'hc8;
  localparam logic [7:0] OFS_VALUE  = 8'hcc;

  // Unlock keys and reset values.
  localparam logic [15:0] KEY_FIRST   = 16'hbaba;
  localparam logic [15:0] KEY_SECOND  = 16'heb10;
  localparam logic [15:0] MATCH_RESET = 16'hffff;
  localparam logic [1:0]  ENABLE_MASK = 2'h3;

  // Unlock sequence stages.
  localparam logic [1:0] STAGE_LOCKED = 2'd0;
  localparam logic [1:0] STAGE_FIRST  = 2'd1;
  localparam logic [1:0] STAGE_OPEN   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  register_offset;
    logic [15:0] write_data;
  } kwdt_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        reset_pulse;
    logic        expired;
  } kwdt_res_t;

endpackage

FILE: rtl/kwdt_in_reg.sv
module kwdt_in_reg import kwdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  kwdt_item_t in_item,
  input  logic       adv,
  output logic       item_valid,
  output kwdt_item_t item
);

  logic       valid_r, valid_nxt;
  kwdt_item_t item_r;

  // The register may load whenever it is empty or its beat moves on.
  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/kwdt_core.sv
module kwdt_core import kwdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  kwdt_item_t item,
  output kwdt_res_t  res
);

  logic [1:0]             stage_r, stage_nxt;
  logic [15:0]            match_r, match_nxt;
  logic [1:0]             enable_r, enable_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   status_r, status_nxt;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_WIDTH-1:0]   count_ext;
  logic [CMP_WIDTH-1:0]   inc_ext;
  logic [CMP_WIDTH-1:0]   match_ext;
  logic                   open;

  assign count_inc = count_r + COUNT_WIDTH'(1);
  assign inc_ext   = CMP_WIDTH'(count_inc);
  assign count_ext = CMP_WIDTH'(count_r);
  assign match_ext = CMP_WIDTH'(match_r);
  assign open      = (stage_r == STAGE_OPEN);

  // Next state and result for the beat in the input register.
  always_comb begin
    stage_nxt       = stage_r;
    match_nxt       = match_r;
    enable_nxt      = enable_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    res.read_data   = 16'h0000;
    res.reset_pulse = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        if (enable_r[0]) begin
          count_nxt = count_inc;
          if (inc_ext == match_ext) begin
            status_nxt      = 1'b1;
            res.reset_pulse = enable_r[1];
          end
        end
      end
      MODE_WRITE: begin
        if (item.register_offset == OFS_FIRST) begin
          stage_nxt = (item.write_data == KEY_FIRST) ? STAGE_FIRST : STAGE_LOCKED;
        end else if (item.register_offset == OFS_SECOND) begin
          stage_nxt = (item.write_data == KEY_SECOND && stage_r == STAGE_FIRST) ?
                      STAGE_OPEN : STAGE_LOCKED;
        end else begin
          // Any other write consumes the unlock, whether or not it lands.
          stage_nxt = STAGE_LOCKED;
          if (open) begin
            case (item.register_offset)
              OFS_ENABLE: enable_nxt = item.write_data[1:0] & ENABLE_MASK;
              OFS_MATCH:  match_nxt  = item.write_data;
              OFS_STATUS: status_nxt = item.write_data[0];
              OFS_CLEAR: begin
                if (item.write_data[0]) begin
                  count_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      MODE_READ: begin
        case (item.register_offset)
          OFS_ENABLE: res.read_data = {14'h0000, enable_r};
          OFS_MATCH:  res.read_data = match_r;
          OFS_STATUS: res.read_data = {15'h0000, status_r};
          OFS_VALUE:  res.read_data = count_ext[15:0];
          default:    res.read_data = 16'h0000;
        endcase
      end
      default: ;
    endcase
    res.expired = status_nxt;
  end

  // Watchdog state advances only when the beat moves to the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= STAGE_LOCKED;
      match_r  <= MATCH_RESET;
      enable_r <= 2'b00;
      count_r  <= '0;
      status_r <= 1'b0;
    end else if (adv) begin
      stage_r  <= stage_nxt;
      match_r  <= match_nxt;
      enable_r <= enable_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

FILE: rtl/keyed_watchdog_timer.sv
// A beat waits in the input register, then its result is held in the output register.
// Throughput: one beat per cycle while the output is drained; while a result waits
// to be taken, a new beat is still taken as long as the input register is empty.
// Reset (rst_n low, synchronous): both channels empty, unlock locked,
// match value 0xffff, counter stopped and zero, status flag clear.
module keyed_watchdog_timer import kwdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] register_offset, [23:8] write_data
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] read_data, [16] reset_pulse, [17] expired,
                                  // [23:18] zero
);

  kwdt_item_t in_item;
  kwdt_item_t item;
  logic       item_valid;
  logic       adv;
  kwdt_res_t  res;
  kwdt_res_t  out_res_r;
  logic       out_valid_r, out_valid_nxt;

  assign in_item.mode            = in_tuser;
  assign in_item.register_offset = in_tdata[7:0];
  assign in_item.write_data      = in_tdata[23:8];

  // A beat moves on when the output register is free or is being drained.
  assign adv = item_valid && (!out_valid_r || out_tready);

  kwdt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  kwdt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_res_r.expired, out_res_r.reset_pulse,
                       out_res_r.read_data};

  // A reset pulse always comes with the status flag set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[17])
    else $error("reset pulse without status flag");

  // Only a read beat returns nonzero read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.mode != MODE_READ |=> out_res_r.read_data == 16'h0000)
    else $error("nonzero read data on a non-read beat");

  // Only a tick beat can raise the reset pulse.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.mode != MODE_TICK |=> !out_res_r.reset_pulse)
    else $error("reset pulse on a non-tick beat");

  // A stalled beat in the input register stays there.
  assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !adv |=> item_valid)
    else $error("input beat lost while stalled");

endmodule
